// File: src/ima_enc_pkg.sv
package ima_enc_pkg;

  localparam int unsigned IdxMax = 88;
  localparam logic [6:0] IDX_MAX = 7'(IdxMax);

  localparam logic [15:0] PRED_MAX = 16'h7FFF;  // 32767
  localparam logic [15:0] PRED_MIN = 16'h8000;  // -32768

  // Header beat positions within the four-byte block header.
  localparam logic [1:0] HDR_LO   = 2'd0;
  localparam logic [1:0] HDR_HI   = 2'd1;
  localparam logic [1:0] HDR_IDX  = 2'd2;
  localparam logic [1:0] HDR_ZERO = 2'd3;

  // One output beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_end;
  } out_beat_t;

  // Result of quantizing one sample against the current predictor.
  typedef struct packed {
    logic [3:0]  code;
    logic [15:0] predictor;
    logic [6:0]  step_index;
  } quant_t;

  // Standard 89-entry IMA step size table.
  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
      7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
      7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Step index adjustment for the magnitude bits of a code.
  function automatic logic [4:0] idx_adjust(input logic [2:0] mag);
    logic [4:0] a;
    case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = 5'b11111;  // minus one
    endcase
    return a;
  endfunction

endpackage

// File: src/ima_enc_quant.sv
module ima_enc_quant (
  input  logic [15:0]           sample_i,
  input  logic [15:0]           predictor_i,
  input  logic [6:0]            step_index_i,
  output ima_enc_pkg::quant_t   res_o
);

  logic [14:0] step;
  logic [16:0] diff;
  logic        neg;
  logic [16:0] mag0, mag1, mag2;
  logic        b2, b1, b0;
  logic [15:0] rec;
  logic [17:0] np;
  logic [7:0]  ni;
  logic [4:0]  adj;

  always_comb begin
    step = ima_enc_pkg::step_size(step_index_i);
    diff = {sample_i[15], sample_i} - {predictor_i[15], predictor_i};
    neg  = diff[16];
    mag0 = neg ? (~diff + 17'd1) : diff;

    // Three compare steps against step, step/2 and step/4; the first two subtract.
    b2   = mag0 >= {2'b0, step};
    mag1 = b2 ? (mag0 - {2'b0, step}) : mag0;
    b1   = mag1 >= {3'b0, step[14:1]};
    mag2 = b1 ? (mag1 - {3'b0, step[14:1]}) : mag1;
    b0   = mag2 >= {4'b0, step[14:2]};

    rec = {4'b0, step[14:3]}
        + (b2 ? {1'b0, step} : 16'd0)
        + (b1 ? {2'b0, step[14:1]} : 16'd0)
        + (b0 ? {3'b0, step[14:2]} : 16'd0);

    np = neg ? ({{2{predictor_i[15]}}, predictor_i} - {2'b0, rec})
             : ({{2{predictor_i[15]}}, predictor_i} + {2'b0, rec});

    res_o.code = {neg, b2, b1, b0};
    if (np[17:15] == 3'b000 || np[17:15] == 3'b111) begin
      res_o.predictor = np[15:0];
    end else if (np[17]) begin
      res_o.predictor = ima_enc_pkg::PRED_MIN;
    end else begin
      res_o.predictor = ima_enc_pkg::PRED_MAX;
    end

    adj = ima_enc_pkg::idx_adjust({b2, b1, b0});
    ni  = {1'b0, step_index_i} + {{3{adj[4]}}, adj};
    if (ni[7]) begin
      res_o.step_index = 7'd0;
    end else if (ni[6:0] > ima_enc_pkg::IDX_MAX) begin
      res_o.step_index = ima_enc_pkg::IDX_MAX;
    end else begin
      res_o.step_index = ni[6:0];
    end
  end

endmodule

// File: src/ima_enc_obuf.sv
module ima_enc_obuf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  ima_enc_pkg::out_beat_t    beat_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      run_last_o,
  output logic                      block_end_o
);

  logic                   valid_q, valid_d;
  ima_enc_pkg::out_beat_t beat_q;

  // The register can take a new beat when empty or when its beat leaves now.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = beat_q.out_byte;
  assign run_last_o  = beat_q.run_last;
  assign block_end_o = beat_q.block_end;

endmodule

// File: src/ima_adpcm_block_encoder_core.sv
// IMA ADPCM block encoder. Signed 16-bit PCM samples enter one beat at a time
// and leave as a byte stream of IMA ADPCM blocks. A sample flagged as first of
// its block loads the predictor and produces a four-byte header (sample low
// byte, sample high byte, current step index, zero); the step index carries
// over between blocks. Every other sample is quantized to a 4-bit code, and
// two codes are packed per byte with the earlier code in the low nibble. A
// block that ends on a low nibble emits that nibble alone. An item with kind
// set clears the predictor and step index and produces no output. Timing: an
// accepted item sits in an input register, the combinational quantizer works
// on it and its result lands in the single output register. A header sample
// stays in the input register until all four header bytes have gone out, one
// byte at a time. Accepted items therefore flow at one per cycle outside
// headers, while the output side keeps up.
module ima_adpcm_block_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] sample_i,
  input  logic        first_of_block_i,
  input  logic        last_of_block_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        block_end_o
);

  // Input register holding the item under work.
  logic        in_valid_q, in_valid_d;
  logic        kind_q, first_q, last_q;
  logic [15:0] sample_q;

  // Encoder state.
  logic [15:0] predictor_q, predictor_d;
  logic [6:0]  step_index_q, step_index_d;
  logic        expect_lo_q, expect_lo_d;
  logic [3:0]  held_q, held_d;

  // Header beat counter.
  logic [1:0]  hdr_beat_q, hdr_beat_d;

  ima_enc_pkg::quant_t    quant;
  ima_enc_pkg::out_beat_t beat;
  logic                   slot_free;
  logic                   emit;
  logic                   consume;
  logic                   in_accept;

  ima_enc_quant u_quant (
    .sample_i     (sample_q),
    .predictor_i  (predictor_q),
    .step_index_i (step_index_q),
    .res_o        (quant)
  );

  ima_enc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .beat_i      (beat),
    .free_o      (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .block_end_o (block_end_o)
  );

  // Decide what the item in the input register does this cycle. Encoder state
  // is only updated when the item is consumed, the header beat counter when a
  // header beat is sent, so a stalled output just holds everything in place.
  always_comb begin
    emit         = 1'b0;
    consume      = 1'b0;
    beat         = '0;
    predictor_d  = predictor_q;
    step_index_d = step_index_q;
    expect_lo_d  = expect_lo_q;
    held_d       = held_q;
    hdr_beat_d   = hdr_beat_q;

    if (in_valid_q) begin
      if (kind_q) begin
        // A clear item touches only the predictor and step index.
        consume      = 1'b1;
        predictor_d  = '0;
        step_index_d = '0;
      end else if (first_q) begin
        // Header: four beats, the last one retires the item.
        case (hdr_beat_q)
          ima_enc_pkg::HDR_LO:   beat.out_byte = sample_q[7:0];
          ima_enc_pkg::HDR_HI:   beat.out_byte = sample_q[15:8];
          ima_enc_pkg::HDR_IDX:  beat.out_byte = {1'b0, step_index_q};
          default:               beat.out_byte = 8'h00;
        endcase
        beat.run_last  = (hdr_beat_q == ima_enc_pkg::HDR_ZERO);
        beat.block_end = (hdr_beat_q == ima_enc_pkg::HDR_ZERO) && last_q;
        if (slot_free) begin
          emit       = 1'b1;
          hdr_beat_d = hdr_beat_q + 2'd1;
          if (hdr_beat_q == ima_enc_pkg::HDR_ZERO) begin
            consume     = 1'b1;
            predictor_d = sample_q;
            expect_lo_d = 1'b1;
            held_d      = '0;
          end
        end
      end else if (expect_lo_q && !last_q) begin
        // Low nibble waits for its partner; nothing goes out.
        consume      = 1'b1;
        predictor_d  = quant.predictor;
        step_index_d = quant.step_index;
        held_d       = quant.code;
        expect_lo_d  = 1'b0;
      end else begin
        if (expect_lo_q) begin
          // Block ends on a low nibble: it goes out alone.
          beat.out_byte  = {4'h0, quant.code};
          beat.run_last  = 1'b1;
          beat.block_end = 1'b1;
        end else begin
          beat.out_byte  = {quant.code, held_q};
          beat.run_last  = 1'b1;
          beat.block_end = last_q;
        end
        if (slot_free) begin
          emit         = 1'b1;
          consume      = 1'b1;
          predictor_d  = quant.predictor;
          step_index_d = quant.step_index;
          held_d       = '0;
          expect_lo_d  = 1'b1;
        end
      end
    end
  end

  assign in_ready_o = !in_valid_q || consume;
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_valid_d = in_accept || (in_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      predictor_q  <= '0;
      step_index_q <= '0;
      expect_lo_q  <= 1'b0;
      held_q       <= '0;
      hdr_beat_q   <= ima_enc_pkg::HDR_LO;
    end else begin
      in_valid_q   <= in_valid_d;
      predictor_q  <= predictor_d;
      step_index_q <= step_index_d;
      expect_lo_q  <= expect_lo_d;
      held_q       <= held_d;
      hdr_beat_q   <= hdr_beat_d;
    end
  end

  // Item payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q   <= kind_i;
      sample_q <= sample_i;
      first_q  <= first_of_block_i;
      last_q   <= last_of_block_i;
    end
  end

endmodule
